// ===== rtl/gjk_pkg.sv =====
// ---------------------------------------------------------------------------
// gjk_pkg
// Shared types and constants of the GJK simplex update unit.
// ---------------------------------------------------------------------------
package gjk_pkg;

   localparam int DIR_W  = 41;
   localparam int SIZE_W = 3;

   typedef enum logic [1:0] {
      VOP_DOT,
      VOP_CROSS,
      VOP_RCROSS
   } vop_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_OUT,
      ST_L_DOT,
      ST_L_CHK,
      ST_L_X1,
      ST_L_X2,
      ST_L_FIN,
      ST_T_N,
      ST_T_X1,
      ST_T_D1,
      ST_T_C1,
      ST_T_C2,
      ST_T_D2,
      ST_T_C3,
      ST_T_C4,
      ST_Q_X1,
      ST_Q_D1,
      ST_Q_C1,
      ST_Q_D2,
      ST_Q_C2,
      ST_Q_D3,
      ST_Q_C3
   } state_type;

endpackage

// ===== rtl/gjk_simplex_update_unit.sv =====
// ---------------------------------------------------------------------------
// gjk_simplex_update_unit
// GJK simplex update: keeps up to four tagged points, runs the line,
// triangle and tetrahedron region tests, returns next search direction.
// ---------------------------------------------------------------------------
// One item is processed at a time; req_stall is high from acceptance until
// the result has been loaded into the output register. A start item (or an
// add after enclosure) goes straight to the output state; an add runs the
// line, triangle or tetrahedron region test step by step on the single
// shared vector unit, which does one cross product or one dot-product sign
// per cycle. A tetrahedron may fall back to a triangle test and a triangle
// to a line test. A stalled output register delays the load.
// A finished result waits in the output register while the next item is
// already accepted.
module gjk_simplex_update_unit #(
   parameter int COORD_BITS = 12,
   parameter int TAG_BITS   = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_mode,
   input  logic signed [COORD_BITS-1:0]       req_point_x,
   input  logic signed [COORD_BITS-1:0]       req_point_y,
   input  logic signed [COORD_BITS-1:0]       req_point_z,
   input  logic [TAG_BITS-1:0]                req_vertex_tag,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [gjk_pkg::DIR_W-1:0]   rsp_dir_x,
   output logic signed [gjk_pkg::DIR_W-1:0]   rsp_dir_y,
   output logic signed [gjk_pkg::DIR_W-1:0]   rsp_dir_z,
   output logic [gjk_pkg::SIZE_W-1:0]         rsp_simplex_size,
   output logic                               rsp_enclosed,
   output logic [TAG_BITS-1:0]                rsp_slot_tag_0,
   output logic [TAG_BITS-1:0]                rsp_slot_tag_1,
   output logic [TAG_BITS-1:0]                rsp_slot_tag_2,
   output logic [TAG_BITS-1:0]                rsp_slot_tag_3
);
   import gjk_pkg::*;

   localparam int CB = COORD_BITS;
   localparam int EW = CB + 1;
   localparam int AW = 3 * EW + 2;
   localparam int XW = (AW > DIR_W) ? AW : DIR_W;

   state_type            state_ff, state_in;
   logic signed [CB-1:0] pts_ff [4][3];
   logic signed [CB-1:0] pts_in [4][3];
   logic [TAG_BITS-1:0]  tag_ff [4];
   logic [TAG_BITS-1:0]  tag_in [4];
   logic [2:0]           cnt_ff, cnt_in;
   logic signed [AW-1:0] n_ff [3];
   logic signed [AW-1:0] n_in [3];
   logic signed [DIR_W-1:0] dir_ff [3];
   logic signed [DIR_W-1:0] dir_in [3];
   logic                 enc_ff, enc_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [DIR_W-1:0] rsp_dir_ff [3];
   logic signed [DIR_W-1:0] rsp_dir_in [3];
   logic [SIZE_W-1:0]    rsp_size_ff, rsp_size_in;
   logic                 rsp_enc_ff, rsp_enc_in;
   logic [TAG_BITS-1:0]  rsp_tag_ff [4];
   logic [TAG_BITS-1:0]  rsp_tag_in [4];

   // simplex geometry, newest point is a
   logic signed [CB-1:0] pa [3];
   logic signed [CB-1:0] pb [3];
   logic signed [CB-1:0] pc [3];
   logic signed [EW-1:0] ab [3];
   logic signed [EW-1:0] ac [3];
   logic signed [EW-1:0] ad [3];
   logic signed [EW-1:0] ao [3];
   logic signed [CB-1:0] req_pt [3];

   vop_type              op;
   logic signed [AW-1:0] op_a [3];
   logic signed [EW-1:0] op_b [3];
   logic signed [AW-1:0] res_v [3];
   logic                 pos;

   function automatic logic signed [DIR_W-1:0] to_dir(input logic signed [AW-1:0] v);
      logic signed [XW-1:0] t;
      t = XW'(v);
      return t[DIR_W-1:0];
   endfunction

   gjk_vec_unit #(
      .EW (EW),
      .AW (AW)
   ) u_vec (
      .clock  (clock),
      .op     (op),
      .op_a   (op_a),
      .op_b   (op_b),
      .res_ff (res_v),
      .pos_ff (pos)
   );

   always_comb begin
      case (cnt_ff)
         3'd2: begin
            pa = pts_ff[1]; pb = pts_ff[0]; pc = pts_ff[0];
         end
         3'd3: begin
            pa = pts_ff[2]; pb = pts_ff[1]; pc = pts_ff[0];
         end
         default: begin
            pa = pts_ff[3]; pb = pts_ff[2]; pc = pts_ff[1];
         end
      endcase
      for (int k = 0; k < 3; k++) begin
         ab[k] = EW'(pb[k]) - EW'(pa[k]);
         ac[k] = EW'(pc[k]) - EW'(pa[k]);
         ad[k] = EW'(pts_ff[0][k]) - EW'(pa[k]);
         ao[k] = -EW'(pa[k]);
      end
   end

   assign req_pt[0] = req_point_x;
   assign req_pt[1] = req_point_y;
   assign req_pt[2] = req_point_z;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      pts_in       = pts_ff;
      tag_in       = tag_ff;
      cnt_in       = cnt_ff;
      n_in         = n_ff;
      dir_in       = dir_ff;
      enc_in       = enc_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_dir_in   = rsp_dir_ff;
      rsp_size_in  = rsp_size_ff;
      rsp_enc_in   = rsp_enc_ff;
      rsp_tag_in   = rsp_tag_ff;
      op           = VOP_DOT;
      for (int k = 0; k < 3; k++) begin
         op_a[k] = '0;
         op_b[k] = '0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               enc_in = 1'b0;
               if (!req_mode || cnt_ff == 3'd0) begin
                  pts_in[0] = req_pt;
                  tag_in[0] = req_vertex_tag;
                  cnt_in    = 3'd1;
                  for (int k = 0; k < 3; k++) begin
                     dir_in[k] = -DIR_W'(req_pt[k]);
                  end
                  state_in = ST_OUT;
               end else if (cnt_ff == 3'd4) begin
                  // simplex already encloses the origin: item ignored
                  enc_in = 1'b1;
                  for (int k = 0; k < 3; k++) begin
                     dir_in[k] = '0;
                  end
                  state_in = ST_OUT;
               end else begin
                  pts_in[cnt_ff[1:0]] = req_pt;
                  tag_in[cnt_ff[1:0]] = req_vertex_tag;
                  cnt_in = cnt_ff + 3'd1;
                  case (cnt_ff)
                     3'd1:    state_in = ST_L_DOT;
                     3'd2:    state_in = ST_T_N;
                     default: state_in = ST_Q_X1;
                  endcase
               end
            end
         end

         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_dir_in   = dir_ff;
               rsp_size_in  = cnt_ff;
               rsp_enc_in   = enc_ff;
               for (int i = 0; i < 4; i++) begin
                  rsp_tag_in[i] = (3'(i) < cnt_ff) ? tag_ff[i] : '0;
               end
               state_in = ST_IDLE;
            end
         end

         // line: a = slot 1, b = slot 0
         ST_L_DOT: begin
            op = VOP_DOT;
            for (int k = 0; k < 3; k++) begin
               op_a[k] = AW'(ab[k]); op_b[k] = ao[k];
            end
            state_in = ST_L_CHK;
         end

         ST_L_CHK: begin
            if (pos) begin
               op = VOP_CROSS;
               for (int k = 0; k < 3; k++) begin
                  op_a[k] = AW'(ab[k]); op_b[k] = ao[k];
               end
               state_in = ST_L_X2;
            end else begin
               pts_in[0] = pts_ff[1];
               tag_in[0] = tag_ff[1];
               cnt_in    = 3'd1;
               for (int k = 0; k < 3; k++) begin
                  dir_in[k] = DIR_W'(ao[k]);
               end
               state_in = ST_OUT;
            end
         end

         ST_L_X1: begin
            op = VOP_CROSS;
            for (int k = 0; k < 3; k++) begin
               op_a[k] = AW'(ab[k]); op_b[k] = ao[k];
            end
            state_in = ST_L_X2;
         end

         ST_L_X2: begin
            op   = VOP_CROSS;
            op_a = res_v;
            op_b = ab;
            state_in = ST_L_FIN;
         end

         ST_L_FIN: begin
            for (int k = 0; k < 3; k++) begin
               dir_in[k] = to_dir(res_v[k]);
            end
            state_in = ST_OUT;
         end

         // triangle: a = slot 2, b = slot 1, c = slot 0
         ST_T_N: begin
            op = VOP_CROSS;
            for (int k = 0; k < 3; k++) begin
               op_a[k] = AW'(ab[k]); op_b[k] = ac[k];
            end
            state_in = ST_T_X1;
         end

         ST_T_X1: begin
            n_in = res_v;
            op   = VOP_CROSS;
            op_a = res_v;
            op_b = ac;
            state_in = ST_T_D1;
         end

         ST_T_D1: begin
            op   = VOP_DOT;
            op_a = res_v;
            op_b = ao;
            state_in = ST_T_C1;
         end

         ST_T_C1: begin
            if (pos) begin
               op = VOP_DOT;
               for (int k = 0; k < 3; k++) begin
                  op_a[k] = AW'(ac[k]); op_b[k] = ao[k];
               end
               state_in = ST_T_C2;
            end else begin
               // ab x abc
               op   = VOP_RCROSS;
               op_a = n_ff;
               op_b = ab;
               state_in = ST_T_D2;
            end
         end

         ST_T_C2: begin
            cnt_in = 3'd2;
            if (pos) begin
               pts_in[1] = pts_ff[2];
               tag_in[1] = tag_ff[2];
               state_in  = ST_L_X1;
            end else begin
               pts_in[0] = pts_ff[1];
               tag_in[0] = tag_ff[1];
               pts_in[1] = pts_ff[2];
               tag_in[1] = tag_ff[2];
               state_in  = ST_L_DOT;
            end
         end

         ST_T_D2: begin
            op   = VOP_DOT;
            op_a = res_v;
            op_b = ao;
            state_in = ST_T_C3;
         end

         ST_T_C3: begin
            if (pos) begin
               pts_in[0] = pts_ff[1];
               tag_in[0] = tag_ff[1];
               pts_in[1] = pts_ff[2];
               tag_in[1] = tag_ff[2];
               cnt_in    = 3'd2;
               state_in  = ST_L_DOT;
            end else begin
               op   = VOP_DOT;
               op_a = n_ff;
               op_b = ao;
               state_in = ST_T_C4;
            end
         end

         ST_T_C4: begin
            if (pos) begin
               for (int k = 0; k < 3; k++) begin
                  dir_in[k] = to_dir(n_ff[k]);
               end
            end else begin
               // origin below the face: flip winding
               pts_in[0] = pts_ff[1];
               tag_in[0] = tag_ff[1];
               pts_in[1] = pts_ff[0];
               tag_in[1] = tag_ff[0];
               for (int k = 0; k < 3; k++) begin
                  dir_in[k] = to_dir(-n_ff[k]);
               end
            end
            state_in = ST_OUT;
         end

         // tetrahedron: a = slot 3, b = slot 2, c = slot 1, d = slot 0
         ST_Q_X1: begin
            op = VOP_CROSS;
            for (int k = 0; k < 3; k++) begin
               op_a[k] = AW'(ab[k]); op_b[k] = ac[k];
            end
            state_in = ST_Q_D1;
         end

         ST_Q_D1, ST_Q_D2, ST_Q_D3: begin
            op   = VOP_DOT;
            op_a = res_v;
            op_b = ao;
            case (state_ff)
               ST_Q_D1: state_in = ST_Q_C1;
               ST_Q_D2: state_in = ST_Q_C2;
               default: state_in = ST_Q_C3;
            endcase
         end

         ST_Q_C1: begin
            if (pos) begin
               pts_in[0] = pts_ff[1]; tag_in[0] = tag_ff[1];
               pts_in[1] = pts_ff[2]; tag_in[1] = tag_ff[2];
               pts_in[2] = pts_ff[3]; tag_in[2] = tag_ff[3];
               cnt_in    = 3'd3;
               state_in  = ST_T_N;
            end else begin
               op = VOP_CROSS;
               for (int k = 0; k < 3; k++) begin
                  op_a[k] = AW'(ac[k]); op_b[k] = ad[k];
               end
               state_in = ST_Q_D2;
            end
         end

         ST_Q_C2: begin
            if (pos) begin
               pts_in[2] = pts_ff[3]; tag_in[2] = tag_ff[3];
               cnt_in    = 3'd3;
               state_in  = ST_T_N;
            end else begin
               op = VOP_CROSS;
               for (int k = 0; k < 3; k++) begin
                  op_a[k] = AW'(ad[k]); op_b[k] = ab[k];
               end
               state_in = ST_Q_D3;
            end
         end

         ST_Q_C3: begin
            if (pos) begin
               pts_in[0] = pts_ff[2]; tag_in[0] = tag_ff[2];
               pts_in[1] = pts_ff[0]; tag_in[1] = tag_ff[0];
               pts_in[2] = pts_ff[3]; tag_in[2] = tag_ff[3];
               cnt_in    = 3'd3;
               state_in  = ST_T_N;
            end else begin
               enc_in = 1'b1;
               for (int k = 0; k < 3; k++) begin
                  dir_in[k] = '0;
               end
               state_in = ST_OUT;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 4; i++) begin
            tag_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         tag_ff       <= tag_in;
      end
   end

   always_ff @(posedge clock) begin
      pts_ff      <= pts_in;
      n_ff        <= n_in;
      dir_ff      <= dir_in;
      enc_ff      <= enc_in;
      rsp_dir_ff  <= rsp_dir_in;
      rsp_size_ff <= rsp_size_in;
      rsp_enc_ff  <= rsp_enc_in;
      rsp_tag_ff  <= rsp_tag_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_dir_x        = rsp_dir_ff[0];
   assign rsp_dir_y        = rsp_dir_ff[1];
   assign rsp_dir_z        = rsp_dir_ff[2];
   assign rsp_simplex_size = rsp_size_ff;
   assign rsp_enclosed     = rsp_enc_ff;
   assign rsp_slot_tag_0   = rsp_tag_ff[0];
   assign rsp_slot_tag_1   = rsp_tag_ff[1];
   assign rsp_slot_tag_2   = rsp_tag_ff[2];
   assign rsp_slot_tag_3   = rsp_tag_ff[3];

endmodule

// ===== rtl/gjk_vec_unit.sv =====
// ---------------------------------------------------------------------------
// gjk_vec_unit
// Shared vector unit: one cross product or one dot-product sign test per
// cycle, result registered.
// ---------------------------------------------------------------------------
module gjk_vec_unit #(
   parameter int EW = 13,
   parameter int AW = 41
) (
   input  logic                 clock,
   input  gjk_pkg::vop_type     op,
   input  logic signed [AW-1:0] op_a [3],
   input  logic signed [EW-1:0] op_b [3],
   output logic signed [AW-1:0] res_ff [3],
   output logic                 pos_ff
);
   import gjk_pkg::*;

   localparam int PW = AW + EW;
   localparam int SW = PW + 2;

   logic signed [AW-1:0] la [3];
   logic signed [EW-1:0] lb [3];
   logic signed [PW-1:0] m1 [3];
   logic signed [PW-1:0] m2 [3];
   logic signed [PW:0]   diff [3];
   logic signed [SW-1:0] sum;
   logic signed [AW-1:0] res_in [3];
   logic                 pos_in;

   always_comb begin
      if (op == VOP_DOT) begin
         la = op_a;
         lb = op_b;
      end else begin
         la[0] = op_a[1]; lb[0] = op_b[2];
         la[1] = op_a[2]; lb[1] = op_b[0];
         la[2] = op_a[0]; lb[2] = op_b[1];
      end
      m1[0] = PW'(la[0]) * PW'(lb[0]);
      m1[1] = PW'(la[1]) * PW'(lb[1]);
      m1[2] = PW'(la[2]) * PW'(lb[2]);
      m2[0] = PW'(op_a[2]) * PW'(op_b[1]);
      m2[1] = PW'(op_a[0]) * PW'(op_b[2]);
      m2[2] = PW'(op_a[1]) * PW'(op_b[0]);
      for (int k = 0; k < 3; k++) begin
         if (op == VOP_RCROSS) begin
            diff[k] = (PW+1)'(m2[k]) - (PW+1)'(m1[k]);
         end else begin
            diff[k] = (PW+1)'(m1[k]) - (PW+1)'(m2[k]);
         end
         res_in[k] = diff[k][AW-1:0];
      end
      sum    = SW'(m1[0]) + SW'(m1[1]) + SW'(m1[2]);
      pos_in = !sum[SW-1] && (sum != '0);
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
      pos_ff <= pos_in;
   end

endmodule

// ===== tb/gjk_simplex_update_checker.sv =====
// ---------------------------------------------------------------------------
// gjk_simplex_update_checker
// Watches both channels of the simplex update unit, keeps its own copy of
// the simplex, predicts each result and compares it field by field.
// ---------------------------------------------------------------------------
module gjk_simplex_update_checker #(
   parameter int COORD_BITS = 12,
   parameter int TAG_BITS   = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_stall,
   input  logic                             req_mode,
   input  logic signed [COORD_BITS-1:0]     req_point_x,
   input  logic signed [COORD_BITS-1:0]     req_point_y,
   input  logic signed [COORD_BITS-1:0]     req_point_z,
   input  logic [TAG_BITS-1:0]              req_vertex_tag,
   input  logic                             rsp_valid,
   input  logic                             rsp_stall,
   input  logic signed [gjk_pkg::DIR_W-1:0] rsp_dir_x,
   input  logic signed [gjk_pkg::DIR_W-1:0] rsp_dir_y,
   input  logic signed [gjk_pkg::DIR_W-1:0] rsp_dir_z,
   input  logic [gjk_pkg::SIZE_W-1:0]       rsp_simplex_size,
   input  logic                             rsp_enclosed,
   input  logic [TAG_BITS-1:0]              rsp_slot_tag_0,
   input  logic [TAG_BITS-1:0]              rsp_slot_tag_1,
   input  logic [TAG_BITS-1:0]              rsp_slot_tag_2,
   input  logic [TAG_BITS-1:0]              rsp_slot_tag_3,
   output int                               fail_count,
   output int                               pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      longint x, y, z;
   } vec_type;

   typedef struct {
      logic [gjk_pkg::DIR_W-1:0] dx, dy, dz;
      logic [2:0]                size;
      logic                      enc;
      logic [TAG_BITS-1:0]       tag [4];
   } update_type;

   vec_type             pts  [4];
   logic [TAG_BITS-1:0] tags [4];
   int                  count;
   update_type          expected_q [$];

   function automatic vec_type vsub(vec_type a, vec_type b);
      vec_type r;
      r.x = a.x - b.x; r.y = a.y - b.y; r.z = a.z - b.z;
      return r;
   endfunction

   function automatic vec_type vneg(vec_type a);
      vec_type r;
      r.x = -a.x; r.y = -a.y; r.z = -a.z;
      return r;
   endfunction

   function automatic vec_type vcross(vec_type a, vec_type b);
      vec_type r;
      r.x = a.y * b.z - a.z * b.y;
      r.y = a.z * b.x - a.x * b.z;
      r.z = a.x * b.y - a.y * b.x;
      return r;
   endfunction

   function automatic longint vdot(vec_type a, vec_type b);
      return a.x * b.x + a.y * b.y + a.z * b.z;
   endfunction

   function automatic void move_slot(int dst, int src);
      pts[dst]  = pts[src];
      tags[dst] = tags[src];
   endfunction

   function automatic vec_type line_region();
      vec_type ab, ao;
      ab = vsub(pts[0], pts[1]);
      ao = vneg(pts[1]);
      if (vdot(ab, ao) > 0) return vcross(vcross(ab, ao), ab);
      move_slot(0, 1);
      count = 1;
      return ao;
   endfunction

   function automatic vec_type keep_ab();
      move_slot(0, 1);
      move_slot(1, 2);
      count = 2;
      return line_region();
   endfunction

   function automatic vec_type triangle_region();
      vec_type             a, ab, ac, ao, n, tp;
      logic [TAG_BITS-1:0] tt;
      a  = pts[2];
      ab = vsub(pts[1], a);
      ac = vsub(pts[0], a);
      ao = vneg(a);
      n  = vcross(ab, ac);
      if (vdot(vcross(n, ac), ao) > 0) begin
         if (vdot(ac, ao) > 0) begin
            move_slot(1, 2);
            count = 2;
            return vcross(vcross(ac, ao), ac);
         end
         return keep_ab();
      end
      if (vdot(vcross(ab, n), ao) > 0) return keep_ab();
      if (vdot(n, ao) > 0) return n;
      // origin below the face: swap the two older points to flip winding
      tp = pts[0];
      tt = tags[0];
      move_slot(0, 1);
      pts[1]  = tp;
      tags[1] = tt;
      return vneg(n);
   endfunction

   function automatic bit tetra_region(output vec_type d);
      vec_type             sp [4];
      logic [TAG_BITS-1:0] st [4];
      vec_type             a, ab, ac, ad, ao;
      int                  pick [3];
      for (int i = 0; i < 4; i++) begin
         sp[i] = pts[i];
         st[i] = tags[i];
      end
      a  = sp[3];
      ab = vsub(sp[2], a);
      ac = vsub(sp[1], a);
      ad = vsub(sp[0], a);
      ao = vneg(a);
      if (vdot(vcross(ab, ac), ao) > 0) pick = '{1, 2, 3};
      else if (vdot(vcross(ac, ad), ao) > 0) pick = '{0, 1, 3};
      else if (vdot(vcross(ad, ab), ao) > 0) pick = '{2, 0, 3};
      else begin
         d = '{0, 0, 0};
         return 1'b1;
      end
      for (int k = 0; k < 3; k++) begin
         pts[k]  = sp[pick[k]];
         tags[k] = st[pick[k]];
      end
      count = 3;
      d = triangle_region();
      return 1'b0;
   endfunction

   function automatic update_type predict_update(logic mode, vec_type p,
                                                 logic [TAG_BITS-1:0] tg);
      update_type r;
      vec_type    d;
      r.enc = 1'b0;
      d     = '{0, 0, 0};
      if (!mode || count == 0) begin
         for (int i = 0; i < 4; i++) begin
            pts[i]  = '{0, 0, 0};
            tags[i] = '0;
         end
         pts[0]  = p;
         tags[0] = tg;
         count   = 1;
         d       = vneg(p);
      end else if (count >= 4) begin
         r.enc = 1'b1;
      end else begin
         pts[count]  = p;
         tags[count] = tg;
         count++;
         if (count == 2) d = line_region();
         else if (count == 3) d = triangle_region();
         else r.enc = tetra_region(d);
      end
      r.dx   = d.x[gjk_pkg::DIR_W-1:0];
      r.dy   = d.y[gjk_pkg::DIR_W-1:0];
      r.dz   = d.z[gjk_pkg::DIR_W-1:0];
      r.size = count[2:0];
      for (int i = 0; i < 4; i++) r.tag[i] = (i < count) ? tags[i] : '0;
      return r;
   endfunction

   assign pending_count = expected_q.size();

   always @(posedge clock) begin
      update_type e;
      vec_type    p;
      if (reset) begin
         count = 0;
         for (int i = 0; i < 4; i++) begin
            pts[i]  = '{0, 0, 0};
            tags[i] = '0;
         end
         expected_q.delete();
         fail_count <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               $error("result with no item pending");
               fail_count <= fail_count + 1;
            end else begin
               e = expected_q.pop_front();
               if (rsp_dir_x !== e.dx || rsp_dir_y !== e.dy || rsp_dir_z !== e.dz ||
                   rsp_simplex_size !== e.size || rsp_enclosed !== e.enc ||
                   rsp_slot_tag_0 !== e.tag[0] || rsp_slot_tag_1 !== e.tag[1] ||
                   rsp_slot_tag_2 !== e.tag[2] || rsp_slot_tag_3 !== e.tag[3]) begin
                  if (rsp_dir_x !== e.dx)
                     $error("dir_x exp %0h got %0h", e.dx, rsp_dir_x);
                  if (rsp_dir_y !== e.dy)
                     $error("dir_y exp %0h got %0h", e.dy, rsp_dir_y);
                  if (rsp_dir_z !== e.dz)
                     $error("dir_z exp %0h got %0h", e.dz, rsp_dir_z);
                  if (rsp_simplex_size !== e.size)
                     $error("simplex_size exp %0d got %0d", e.size, rsp_simplex_size);
                  if (rsp_enclosed !== e.enc)
                     $error("enclosed exp %0d got %0d", e.enc, rsp_enclosed);
                  if (rsp_slot_tag_0 !== e.tag[0])
                     $error("slot_tag_0 exp %0h got %0h", e.tag[0], rsp_slot_tag_0);
                  if (rsp_slot_tag_1 !== e.tag[1])
                     $error("slot_tag_1 exp %0h got %0h", e.tag[1], rsp_slot_tag_1);
                  if (rsp_slot_tag_2 !== e.tag[2])
                     $error("slot_tag_2 exp %0h got %0h", e.tag[2], rsp_slot_tag_2);
                  if (rsp_slot_tag_3 !== e.tag[3])
                     $error("slot_tag_3 exp %0h got %0h", e.tag[3], rsp_slot_tag_3);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_valid && !req_stall) begin
            p.x = longint'(req_point_x);
            p.y = longint'(req_point_y);
            p.z = longint'(req_point_z);
            expected_q.push_back(predict_update(req_mode, p, req_vertex_tag));
         end
      end
   end

endmodule

// ===== tb/gjk_simplex_update_unit_test.sv =====
// ---------------------------------------------------------------------------
// gjk_simplex_update_unit_test
// Drives start and add items into the simplex update unit: directed corner
// points, then random GJK-like runs under varying idle and stall rates.
// ---------------------------------------------------------------------------
module gjk_simplex_update_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int  COORD_BITS = 12;
   localparam int  TAG_BITS   = 8;
   localparam int  CYCLE_LIMIT = 400000;
   localparam logic MODE_START = 1'b0;
   localparam logic MODE_ADD   = 1'b1;

   logic clock, reset;
   logic req_valid, req_stall, req_mode;
   logic signed [COORD_BITS-1:0] req_point_x, req_point_y, req_point_z;
   logic [TAG_BITS-1:0]          req_vertex_tag;
   logic rsp_valid, rsp_stall;
   logic signed [gjk_pkg::DIR_W-1:0] rsp_dir_x, rsp_dir_y, rsp_dir_z;
   logic [gjk_pkg::SIZE_W-1:0] rsp_simplex_size;
   logic rsp_enclosed;
   logic [TAG_BITS-1:0] rsp_slot_tag_0, rsp_slot_tag_1, rsp_slot_tag_2, rsp_slot_tag_3;
   int   fail_count, pending_count;
   int   cycle_count;
   int   send_idle_pct, stall_pct;
   bit   hold_off;

   gjk_simplex_update_unit #(.COORD_BITS(COORD_BITS), .TAG_BITS(TAG_BITS)) u_top (.*);

   gjk_simplex_update_checker #(.COORD_BITS(COORD_BITS), .TAG_BITS(TAG_BITS)) u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   // receiver: random stall, or a long hold-off when asked
   initial begin
      rsp_stall = 1'b1;
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp_stall <= 1'b1;
            repeat (300) @(posedge clock);
            hold_off = 1'b0;
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // valid stays high after acceptance; the next item or an idle cycle replaces it
   task automatic send_item(logic mode, int x, int y, int z, int tg);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_mode       <= mode;
      req_point_x    <= x[COORD_BITS-1:0];
      req_point_y    <= y[COORD_BITS-1:0];
      req_point_z    <= z[COORD_BITS-1:0];
      req_vertex_tag <= tg[TAG_BITS-1:0];
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   function automatic int rand_coord(int span);
      return $signed($urandom_range(2 * span)) - span;
   endfunction

   // one GJK-like run: a start then one to six more items, mostly adds, mostly small spread
   task automatic send_run(output int items);
      int span, n;
      span = ($urandom_range(3) == 0) ? 2047 : (($urandom_range(1) == 0) ? 20 : 400);
      n = $urandom_range(1, 6);
      send_item(MODE_START, rand_coord(span), rand_coord(span), rand_coord(span),
                $urandom_range(255));
      for (int i = 0; i < n; i++)
         send_item(($urandom_range(15) == 0) ? MODE_START : MODE_ADD,
                   rand_coord(span), rand_coord(span), rand_coord(span), $urandom_range(255));
      items = n + 1;
   endtask

   initial begin
      int sent;
      int k;
      req_valid = 1'b0; req_mode = MODE_START;
      req_point_x = '0; req_point_y = '0; req_point_z = '0; req_vertex_tag = '0;
      send_idle_pct = 0; stall_pct = 0; hold_off = 1'b0;
      reset = 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // add on empty simplex acts as a start
      send_item(MODE_ADD, 2047, -2048, 5, 8'hff);
      send_item(MODE_START, -2048, -2048, -2048, 8'h00);
      send_item(MODE_ADD, 2047, 2047, 2047, 8'haa);
      // tetrahedron around the origin, then adds after enclosure
      send_item(MODE_START, 10, 0, -10, 8'h11);
      send_item(MODE_ADD, -10, 10, -10, 8'h22);
      send_item(MODE_ADD, -10, -10, -10, 8'h33);
      send_item(MODE_ADD, 0, 0, 10, 8'h44);
      send_item(MODE_ADD, 1, 1, 1, 8'h55);
      send_item(MODE_ADD, -2048, 2047, 0, 8'h66);
      // origin on the line: zero cross product
      send_item(MODE_START, 5, 5, 5, 8'h01);
      send_item(MODE_ADD, -5, -5, -5, 8'h02);
      // line dropping the old point, then a triangle, then all-zero points
      send_item(MODE_START, 100, 0, 0, 8'h80);
      send_item(MODE_ADD, 50, 0, 0, 8'h7f);
      send_item(MODE_ADD, 0, 100, 0, 8'h0f);
      send_item(MODE_ADD, 0, 0, 100, 8'hf0);
      send_item(MODE_START, 0, 0, 0, 8'h5a);
      send_item(MODE_ADD, 0, 0, 0, 8'ha5);
      send_item(MODE_ADD, 0, 0, 0, 8'h3c);
      send_item(MODE_ADD, 0, 0, 0, 8'hc3);

      sent = 0;
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 65 : 21) : 0;
         stall_pct     = (ph == 2) ? 65 : ((ph == 3) ? 21 : 0);
         if (ph == 2) hold_off = 1'b1;
         while (sent < (ph + 1) * 170) begin
            send_run(k);
            sent += k;
         end
         // sender waits until the block has drained
         wait_drained();
      end

      wait_drained();
      repeat (40) @(posedge clock);
      if (fail_count == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule
